>>> rtl/arm_joint_pd_gravity_control_unit_macros.svh
// assertion helpers for the joint controller
`ifndef ARM_JOINT_PD_GRAVITY_CONTROL_UNIT_MACROS_SVH
`define ARM_JOINT_PD_GRAVITY_CONTROL_UNIT_MACROS_SVH

// implication checked on every edge outside reset
`define AJ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AJ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ajpd_pkg.sv
// ----------------------------------------------------------------------------
// ajpd_pkg
// types and constants shared by the joint controller modules
// ----------------------------------------------------------------------------
package ajpd_pkg;

  localparam int unsigned NumJoints = 3;
  localparam logic [17:0] InvTwoPiQ16 = 18'd166886;
  localparam logic [14:0] SinA = 15'd25736;
  localparam logic [13:0] SinB = 14'd10512;
  localparam logic [10:0] SinC = 11'd1160;

  typedef enum logic [2:0] {
    REG_MODE  = 3'd0,
    REG_KP    = 3'd1,
    REG_KD    = 3'd2,
    REG_COEFA = 3'd3,
    REG_COEFB = 3'd4,
    REG_COEFC = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    MODE_GRAV = 2'd0,
    MODE_P    = 2'd1,
    MODE_PG   = 2'd2,
    MODE_PDG  = 2'd3
  } mode_e;

  typedef struct packed {
    logic signed [15:0] joint_angle_1;
    logic signed [15:0] joint_angle_2;
    logic signed [15:0] joint_angle_3;
    logic signed [15:0] target_angle_1;
    logic signed [15:0] target_angle_2;
    logic signed [15:0] target_angle_3;
    logic signed [15:0] joint_velocity_1;
    logic signed [15:0] joint_velocity_2;
    logic signed [15:0] joint_velocity_3;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] torque_1;
    logic signed [31:0] torque_2;
    logic signed [31:0] torque_3;
  } out_item_t;

  // per-lane operands: angle sum, coefficient, position error, velocity
  typedef struct packed {
    logic signed [17:0] ang;
    logic        [23:0] coef;
    logic signed [16:0] err;
    logic signed [15:0] vel;
    logic               cos_sel;
  } lane_in_t;

  // per-lane rounded terms, all Q16
  typedef struct packed {
    logic signed [39:0] g;
    logic signed [41:0] p;
    logic signed [40:0] d;
  } lane_out_t;

  // rounding shift, half away from zero
  function automatic logic signed [47:0] shr_round(input logic signed [47:0] v,
                                                   input int unsigned sh);
    logic [47:0] m;
    logic [47:0] r;
    m = v[47] ? 48'(-v) : 48'(v);
    r = (m + (48'd1 << (sh - 1))) >> sh;
    return v[47] ? 48'(-r) : 48'(r);
  endfunction

endpackage

>>> rtl/arm_joint_pd_gravity_control_unit.sv
// ----------------------------------------------------------------------------
// arm_joint_pd_gravity_control_unit
// three-link arm PD controller with gravity compensation
// ----------------------------------------------------------------------------
// One item of three angles, targets and velocities gives one item of three
// saturated torques. Three lanes work side by side (cos q1, sin q1+q2,
// sin q1+q2+q3, each with its joint's P and D products) through a 7-stage
// pipeline, then a merge and an output register: one item per cycle
// sustained while not stalled. The whole pipeline advances when the output
// register is empty or being taken, so a stall holds every stage in place.
module arm_joint_pd_gravity_control_unit import ajpd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);
  `include "arm_joint_pd_gravity_control_unit_macros.svh"

  localparam int unsigned Depth = 7;

  logic [1:0]  mode_q;
  logic [23:0] kp_q, kd_q, ca_q, cb_q, cc_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0; kp_q <= '0; kd_q <= '0; ca_q <= '0; cb_q <= '0; cc_q <= '0;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_MODE:  mode_q <= cfg_data_i[1:0];
        REG_KP:    kp_q   <= cfg_data_i;
        REG_KD:    kd_q   <= cfg_data_i;
        REG_COEFA: ca_q   <= cfg_data_i;
        REG_COEFB: cb_q   <= cfg_data_i;
        REG_COEFC: cc_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic adv;
  logic [Depth-1:0] vld_q;
  logic out_vld_q;
  out_item_t out_q;

  assign adv        = !out_vld_q || !out_stall_i;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[Depth-2:0], in_valid_i};
      out_vld_q <= vld_q[Depth-1];
    end
  end

  lane_in_t  li [NumJoints];
  lane_out_t lo [NumJoints];
  logic signed [17:0] a12;

  always_comb begin
    a12 = 18'(in_item_i.joint_angle_1) + 18'(in_item_i.joint_angle_2);
    li[0].ang = 18'(in_item_i.joint_angle_1);
    li[0].coef = ca_q;
    li[0].cos_sel = 1'b1;
    li[0].err = 17'(in_item_i.joint_angle_1) - 17'(in_item_i.target_angle_1);
    li[0].vel = in_item_i.joint_velocity_1;
    li[1].ang = a12;
    li[1].coef = cb_q;
    li[1].cos_sel = 1'b0;
    li[1].err = 17'(in_item_i.joint_angle_2) - 17'(in_item_i.target_angle_2);
    li[1].vel = in_item_i.joint_velocity_2;
    li[2].ang = a12 + 18'(in_item_i.joint_angle_3);
    li[2].coef = cc_q;
    li[2].cos_sel = 1'b0;
    li[2].err = 17'(in_item_i.joint_angle_3) - 17'(in_item_i.target_angle_3);
    li[2].vel = in_item_i.joint_velocity_3;
  end

  for (genvar j = 0; j < NumJoints; j++) begin : g_lane
    ajpd_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .lane_i (li[j]),
      .kp_i   (kp_q),
      .kd_i   (kd_q),
      .lane_o (lo[j])
    );
  end

  out_item_t merged;

  ajpd_merge u_merge (
    .mode_i   (mode_q),
    .lane_a_i (lo[0]),
    .lane_b_i (lo[1]),
    .lane_c_i (lo[2]),
    .item_o   (merged)
  );

  always_ff @(posedge clk_i) begin
    if (adv) out_q <= merged;
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  `AJ_ASSERT_NXT(a_hold_out, clk_i, rst_ni, out_vld_q && out_stall_i, out_vld_q && $stable(out_q), "stalled output changed")
  `AJ_ASSERT_IMP(a_stall_iff_full, clk_i, rst_ni, in_stall_o, out_vld_q && out_stall_i, "input stalled without cause")
  `AJ_ASSERT_NXT(a_pipe_feed, clk_i, rst_ni, adv && vld_q[Depth-1], out_vld_q, "item lost at pipe end")

endmodule

>>> rtl/ajpd_lane.sv
// ----------------------------------------------------------------------------
// ajpd_lane
// one joint lane: phase, polynomial sine, gravity/P/D products, pipelined
// ----------------------------------------------------------------------------
module ajpd_lane import ajpd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  lane_in_t    lane_i,
  input  logic [23:0] kp_i,
  input  logic [23:0] kd_i,
  output lane_out_t   lane_o
);

  // stage 1: phase product and gain products
  logic signed [35:0] phase_prod_q;
  logic               cos_q;
  logic        [23:0] coef1_q;
  logic signed [41:0] pprod_q;
  logic signed [40:0] dprod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      phase_prod_q <= 36'(lane_i.ang) * 36'(signed'({18'd0, InvTwoPiQ16}));
      cos_q        <= lane_i.cos_sel;
      coef1_q      <= lane_i.coef;
      pprod_q      <= 42'(signed'({1'b0, kp_i})) * 42'(lane_i.err);
      dprod_q      <= 41'(signed'({1'b0, kd_i})) * 41'(lane_i.vel);
    end
  end

  // stage 2: phase, quadrant folding, z squared
  logic [35:0] ph_sum;
  logic [15:0] ph;
  logic [13:0] r;
  logic [14:0] z_d;
  logic [14:0] z_q;
  logic [14:0] z2_q;
  logic        neg_q;
  logic [23:0] coef2_q;
  logic signed [41:0] p2_q;
  logic signed [40:0] d2_q;
  logic [29:0] zz;

  always_comb begin
    ph_sum = phase_prod_q + 36'h8000;
    ph     = ph_sum[31:16] + (cos_q ? 16'h4000 : 16'h0);
    r      = ph[13:0];
    z_d    = ph[14] ? (15'd16384 - 15'(r)) : 15'(r);
    zz     = z_d * z_d;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z_q     <= z_d;
      // z squared reaches 16384 at a full quarter turn
      z2_q    <= zz[28:14];
      neg_q   <= ph[15];
      coef2_q <= coef1_q;
      p2_q    <= pprod_q;
      d2_q    <= dprod_q;
    end
  end

  // stage 3: first polynomial step
  logic [24:0] t1m;
  logic [13:0] t1_q;
  logic [14:0] z3_q;
  logic [14:0] z23_q;
  logic        neg3_q;
  logic [23:0] coef3_q;
  logic signed [41:0] p3_q;
  logic signed [40:0] d3_q;
  assign t1m = z2_q * SinC;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_q    <= SinB - 14'(t1m[24:14]);
      z3_q    <= z_q;
      z23_q   <= z2_q;
      neg3_q  <= neg_q;
      coef3_q <= coef2_q;
      p3_q    <= p2_q;
      d3_q    <= d2_q;
    end
  end

  // stage 4: second polynomial step
  logic [27:0] t2m;
  logic [14:0] t2_q;
  logic [14:0] z4_q;
  logic        neg4_q;
  logic [23:0] coef4_q;
  logic signed [41:0] p4_q;
  logic signed [40:0] d4_q;
  assign t2m = z23_q * t1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t2_q    <= SinA - 15'(t2m[27:14]);
      z4_q    <= z3_q;
      neg4_q  <= neg3_q;
      coef4_q <= coef3_q;
      p4_q    <= p3_q;
      d4_q    <= d3_q;
    end
  end

  // stage 5: sine value
  logic [29:0] sm;
  logic signed [15:0] s_q;
  logic [23:0] coef5_q;
  logic signed [41:0] p5_q;
  logic signed [40:0] d5_q;
  assign sm = z4_q * t2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q     <= neg4_q ? -16'(sm[29:14]) : 16'(sm[29:14]);
      coef5_q <= coef4_q;
      p5_q    <= p4_q;
      d5_q    <= d4_q;
    end
  end

  // stage 6: coefficient product
  logic signed [40:0] gprod_q;
  logic signed [41:0] p6_q;
  logic signed [40:0] d6_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      gprod_q <= 41'(signed'({1'b0, coef5_q})) * 41'(s_q);
      p6_q    <= p5_q;
      d6_q    <= d5_q;
    end
  end

  // stage 7: rounding
  logic [47:0] gr;
  logic [47:0] pr;
  logic [47:0] dr;
  assign gr = shr_round(48'(gprod_q), 14);
  assign pr = shr_round(48'(p6_q), 8);
  assign dr = shr_round(48'(d6_q), 6);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_o.g <= signed'(gr[39:0]);
      lane_o.p <= signed'(pr[41:0]);
      lane_o.d <= signed'(dr[40:0]);
    end
  end

  logic unused_ok;
  assign unused_ok = ^{rst_ni, zz[29], ph_sum[35:32], ph_sum[15:0],
                       t2m[13:0], t1m[13:0], sm[13:0], zz[13:0]};

endmodule

>>> rtl/ajpd_merge.sv
// ----------------------------------------------------------------------------
// ajpd_merge
// sums the lane terms per mode and saturates each torque
// ----------------------------------------------------------------------------
module ajpd_merge import ajpd_pkg::*; (
  input  logic      [1:0] mode_i,
  input  lane_out_t       lane_a_i,
  input  lane_out_t       lane_b_i,
  input  lane_out_t       lane_c_i,
  output out_item_t       item_o
);

  function automatic logic signed [31:0] sat32(input logic signed [44:0] v);
    if (v > 45'sd2147483647) return 32'sh7fffffff;
    if (v < -45'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  logic signed [44:0] g [NumJoints];
  logic signed [44:0] p [NumJoints];
  logic signed [44:0] d [NumJoints];
  logic signed [44:0] tau [NumJoints];

  always_comb begin
    g[2] = 45'(lane_c_i.g);
    g[1] = 45'(lane_b_i.g) + g[2];
    g[0] = 45'(lane_a_i.g) + g[1];
    p[0] = 45'(lane_a_i.p);
    p[1] = 45'(lane_b_i.p);
    p[2] = 45'(lane_c_i.p);
    d[0] = 45'(lane_a_i.d);
    d[1] = 45'(lane_b_i.d);
    d[2] = 45'(lane_c_i.d);
    for (int i = 0; i < NumJoints; i++) begin
      case (mode_e'(mode_i))
        MODE_GRAV: tau[i] = -g[i];
        MODE_P:    tau[i] = -p[i];
        MODE_PG:   tau[i] = -g[i] - p[i];
        default:   tau[i] = -g[i] - p[i] - d[i];
      endcase
    end
    item_o.torque_1 = sat32(tau[0]);
    item_o.torque_2 = sat32(tau[1]);
    item_o.torque_3 = sat32(tau[2]);
  end

endmodule

>>> sim/tb_arm_joint_pd_gravity_control_unit.sv
// ----------------------------------------------------------------------------
// tb_arm_joint_pd_gravity_control_unit
// self-checking bench for the three-link arm pd controller with gravity terms
// ----------------------------------------------------------------------------
// Drives angle/target/velocity items through the stall handshake with bursty
// gaps and a stalling receiver, predicts each torque triple with a local
// fixed-point model and compares every result field by field. Register writes
// happen only while the pipeline is drained, across all modes and gain limits.
module tb_arm_joint_pd_gravity_control_unit;
  import ajpd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DrainCycles = 12;
  localparam int WatchdogLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_item_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_item_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [23:0] cfg_data_i = '0;

  arm_joint_pd_gravity_control_unit dut (.*);

  always #6 clk_i = ~clk_i;

  // local copy of the control registers
  mode_e        mode_q;
  logic [23:0]  kp_q, kd_q, coef_a_q, coef_b_q, coef_c_q;

  out_item_t torque_queue[$];
  int        errors = 0;
  int        items_sent = 0;
  int        results_seen = 0;
  int        idle_cycles = 0;
  int        send_gap = 0;
  int        stall_mode = 0;

  function automatic logic [15:0] to_phase(input logic signed [17:0] ang);
    logic signed [63:0] prod;
    prod = 64'(ang) * 64'sd166886;
    return 16'((prod + 64'sd32768) >>> 16);
  endfunction

  function automatic longint poly_sine(input logic [15:0] ph);
    longint r, z, z2, t, s;
    r = longint'(ph[13:0]);
    z = ph[14] ? 16384 - r : r;
    z2 = (z * z) >>> 14;
    t = 10512 - ((z2 * 1160) >>> 14);
    t = 25736 - ((z2 * t) >>> 14);
    s = (z * t) >>> 14;
    return ph[15] ? -s : s;
  endfunction

  function automatic longint round_shift(input longint v, input int sh);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (longint'(1) << (sh - 1))) >>> sh;
    return (v < 0) ? -m : m;
  endfunction

  function automatic logic [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return 32'(v);
  endfunction

  function automatic out_item_t predict_torques(input in_item_t it);
    longint q[3], qd[3], dq[3], g[3];
    longint ta, tb, tc, p, d, tau;
    logic [31:0] res[3];
    out_item_t o;
    q  = '{longint'(it.joint_angle_1), longint'(it.joint_angle_2),
           longint'(it.joint_angle_3)};
    qd = '{longint'(it.target_angle_1), longint'(it.target_angle_2),
           longint'(it.target_angle_3)};
    dq = '{longint'(it.joint_velocity_1), longint'(it.joint_velocity_2),
           longint'(it.joint_velocity_3)};
    // cosine is the sine a quarter turn ahead
    ta = round_shift(longint'(coef_a_q) *
                     poly_sine(to_phase(18'(q[0])) + 16'd16384), 14);
    tb = round_shift(longint'(coef_b_q) * poly_sine(to_phase(18'(q[0] + q[1]))), 14);
    tc = round_shift(longint'(coef_c_q) *
                     poly_sine(to_phase(18'(q[0] + q[1] + q[2]))), 14);
    g = '{ta + tb + tc, tb + tc, tc};
    for (int i = 0; i < 3; i++) begin
      p = round_shift(longint'(kp_q) * (q[i] - qd[i]), 8);
      d = round_shift(longint'(kd_q) * dq[i], 6);
      case (mode_q)
        MODE_GRAV: tau = -g[i];
        MODE_P:    tau = -p;
        MODE_PG:   tau = -g[i] - p;
        default:   tau = -g[i] - p - d;
      endcase
      res[i] = clamp32(tau);
    end
    o.torque_1 = res[0];
    o.torque_2 = res[1];
    o.torque_3 = res[2];
    return o;
  endfunction

  // receiver stall pattern, changes character every so often
  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 1) == 0);
      default: out_stall_i <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // result checker
  always @(posedge clk_i) begin
    out_item_t exp_t;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (torque_queue.size() == 0) begin
        $error("result with no torque expected");
        errors++;
      end else begin
        exp_t = torque_queue.pop_front();
        if (out_item_o.torque_1 !== exp_t.torque_1) begin
          $error("torque_1 expected %0d got %0d", exp_t.torque_1, out_item_o.torque_1);
          errors++;
        end
        if (out_item_o.torque_2 !== exp_t.torque_2) begin
          $error("torque_2 expected %0d got %0d", exp_t.torque_2, out_item_o.torque_2);
          errors++;
        end
        if (out_item_o.torque_3 !== exp_t.torque_3) begin
          $error("torque_3 expected %0d got %0d", exp_t.torque_3, out_item_o.torque_3);
          errors++;
        end
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      idle_cycles <= 0;
    else if (in_valid_i || torque_queue.size() != 0 || cfg_valid_i) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog expired");
        $display("FAILURE");
        $finish;
      end
    end
  end

  // valid stays high after an accepted item so bursts run back to back;
  // gaps and drain drop it
  task automatic send_item(input in_item_t it);
    int gap_len;
    // bursty sender: a random gap ahead of some items
    if (send_gap == 0) begin
      send_gap = $urandom_range(1, 20);
      gap_len = $urandom_range(0, 6);
      if (gap_len > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap_len) @(posedge clk_i);
      end
    end
    send_gap--;
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    torque_queue.push_back(predict_torques(it));
    items_sent++;
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (torque_queue.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [23:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_MODE:  mode_q = mode_e'(val[1:0]);
      REG_KP:    kp_q = val;
      REG_KD:    kd_q = val;
      REG_COEFA: coef_a_q = val;
      REG_COEFB: coef_b_q = val;
      REG_COEFC: coef_c_q = val;
      default: ;
    endcase
  endtask

  task automatic set_all(input mode_e m, input logic [23:0] kp, kd, a, b, c);
    drain();
    write_reg(REG_MODE, 24'(m));
    write_reg(REG_KP, kp);
    write_reg(REG_KD, kd);
    write_reg(REG_COEFA, a);
    write_reg(REG_COEFB, b);
    write_reg(REG_COEFC, c);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic in_item_t random_item(input int span);
    in_item_t it;
    logic [15:0] f[9];
    for (int i = 0; i < 9; i++) begin
      case ($urandom_range(0, 5))
        0: f[i] = 16'h8000;
        1: f[i] = 16'h7fff;
        2, 3: f[i] = 16'($signed($urandom_range(0, 2 * span)) - span);
        default: f[i] = 16'($urandom);
      endcase
    end
    it = {f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7], f[8]};
    return it;
  endfunction

  function automatic in_item_t fill_item(input logic [15:0] q, qd, dq);
    return {q, q, q, qd, qd, qd, dq, dq, dq};
  endfunction

  task automatic test_directed;
    // all four modes, limits of fields and gains, angle wrap, saturation
    set_all(MODE_PDG, 24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff);
    send_item(fill_item(16'h7fff, 16'h8000, 16'h7fff));
    send_item(fill_item(16'h8000, 16'h7fff, 16'h8000));
    send_item(fill_item(16'h0000, 16'h0000, 16'h0000));
    send_item(fill_item(16'hffff, 16'h0001, 16'hffff));
    send_item(fill_item(16'd6434, 16'd0, 16'd1));
    set_all(MODE_GRAV, 24'd4096, 24'd4096, 24'd65536, 24'd131072, 24'd32768);
    send_item(fill_item(16'd0, 16'd100, 16'd5));
    send_item(fill_item(16'd6434, 16'd0, 16'd0));
    send_item(fill_item(16'hcdde, 16'd0, 16'd0));
    send_item(fill_item(16'h7fff, 16'd0, 16'd0));
    set_all(MODE_P, 24'd4096, 24'd0, 24'hffffff, 24'hffffff, 24'hffffff);
    send_item(fill_item(16'd1000, 16'hfc18, 16'd300));
    send_item(fill_item(16'h7fff, 16'h8000, 16'd0));
    set_all(MODE_PG, 24'hffffff, 24'd9, 24'd0, 24'd0, 24'd0);
    send_item(fill_item(16'h7fff, 16'h8000, 16'h7fff));
    send_item(fill_item(16'h8000, 16'h7fff, 16'd3));
    set_all(MODE_PDG, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
    send_item(fill_item(16'h1234, 16'h4321, 16'h7fff));
    // out-of-range index must leave registers alone
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= 3'd7;
    cfg_data_i  <= 24'hffffff;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    send_item(fill_item(16'h0777, 16'h0111, 16'h0222));
  endtask

  task automatic test_random;
    mode_e m;
    for (int phase = 0; phase < 16; phase++) begin
      m = mode_e'(phase % 4);
      if (phase >= 12)
        set_all(m, 24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff);
      else
        set_all(m, 24'($urandom), 24'($urandom_range(0, 65535)), 24'($urandom),
                24'($urandom), 24'($urandom_range(0, 4194304)));
      repeat (102) send_item(random_item(phase < 8 ? 8000 : 32767));
    end
  endtask

  initial begin
    mode_q = MODE_GRAV;
    kp_q = '0; kd_q = '0; coef_a_q = '0; coef_b_q = '0; coef_c_q = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    drain();
    $display("sent %0d items, checked %0d torque results", items_sent, results_seen);
    $display("all four control modes, gain and coefficient limits, angle wrap covered");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
